// ----- hdl/nhrag_pkg.sv -----
// ----------------------------------------------------------------------------
// NHR all-gather schedule package
// Shared widths, codes and types for the schedule generator and its parts.
// ----------------------------------------------------------------------------
package nhrag_pkg;

  localparam int RANK_W         = 6;
  localparam int CNT_W          = 7;
  localparam int STEP_W         = 3;
  localparam int CH_W           = 4;
  localparam int MAX_RANKS_DEF  = 64;
  localparam int PEER_SLOTS_DEF = 12;

  localparam logic [CH_W-1:0] CH_OVF = 4'd15;

  typedef enum logic [1:0] {
    OP_ADD_MOD = 2'd0,
    OP_SUB_MOD = 2'd1,
    OP_ADD     = 2'd2
  } op_t;

  typedef struct packed {
    logic              clear;
    logic              valid;
    logic [RANK_W-1:0] rank;
  } peer_req_t;

  typedef struct packed {
    logic            done;
    logic [CH_W-1:0] channel;
  } peer_rsp_t;

  function automatic logic [STEP_W-1:0] bit_length(input logic [CNT_W-1:0] v);
    logic [STEP_W-1:0] n;
    n = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) begin
        n = STEP_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ----- hdl/nhr_allgather_schedule_gen.sv -----
// Each table search walks the stored partners at one entry per cycle (up to 12). Results come
// one per cycle while a step's slices are emitted; busy stays high until the final beat.
// Bad parameters give a single error beat in the cycle after start is taken; busy stays low.
// Reset (rst, synchronous) returns the sequencer to idle and empties the peer table.
// The receiver cannot stall: each beat is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// NHR all-gather schedule generator
// Sequencer around a shared modular adder and a first-seen peer table.
// ----------------------------------------------------------------------------
module nhr_allgather_schedule_gen #(
  parameter int MAX_RANKS  = nhrag_pkg::MAX_RANKS_DEF,
  parameter int PEER_SLOTS = nhrag_pkg::PEER_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [nhrag_pkg::RANK_W-1:0]  my_rank,
  input  logic [nhrag_pkg::CNT_W-1:0]   rank_count,
  output logic                          valid,
  output logic                          status,
  output logic [nhrag_pkg::STEP_W-1:0]  step_index,
  output logic [nhrag_pkg::RANK_W-1:0]  send_rank,
  output logic [nhrag_pkg::RANK_W-1:0]  recv_rank,
  output logic [nhrag_pkg::RANK_W-1:0]  slice_index,
  output logic [nhrag_pkg::CH_W-1:0]    send_channel,
  output logic [nhrag_pkg::CH_W-1:0]    recv_channel,
  output logic                          step_end,
  output logic                          last
);
  import nhrag_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_TO   = 10'b00_0000_0010,
    S_FROM = 10'b00_0000_0100,
    S_BACK = 10'b00_0000_1000,
    S_NSL  = 10'b00_0001_0000,
    S_PRF  = 10'b00_0010_0000,
    S_PWF  = 10'b00_0100_0000,
    S_PRT  = 10'b00_1000_0000,
    S_PWT  = 10'b01_0000_0000,
    S_EMIT = 10'b10_0000_0000
  } state_t;

  state_t            state;
  logic [RANK_W-1:0] rank_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  cm1_q;
  logic [STEP_W-1:0] steps_q;
  logic [STEP_W-1:0] s_q;
  logic [RANK_W-1:0] to_q;
  logic [RANK_W-1:0] from_q;
  logic [RANK_W-1:0] back_q;
  logic [RANK_W-1:0] nsl_q;
  logic [RANK_W-1:0] k_q;
  logic [RANK_W-1:0] tx_q;
  logic [CH_W-1:0]   fch_q;
  logic [CH_W-1:0]   tch_q;

  logic              accept;
  logic              bad;
  logic [CNT_W-1:0]  cm1_in;
  logic [STEP_W-1:0] shamt;
  logic [CNT_W-1:0]  span;
  logic [CNT_W-1:0]  stride;
  logic              se;
  logic              fin;
  op_t               op;
  logic [CNT_W-1:0]  ua;
  logic [CNT_W-1:0]  ub;
  logic [CNT_W-1:0]  ur;
  peer_req_t         preq;
  peer_rsp_t         prsp;

  always_comb begin
    accept = start && (state == S_IDLE);
    bad    = (rank_count < CNT_W'(2)) || (rank_count > CNT_W'(MAX_RANKS)) ||
             ({1'b0, my_rank} >= rank_count);
    cm1_in = rank_count - CNT_W'(1);
    shamt  = steps_q - s_q;
    span   = CNT_W'(1) << shamt;
    stride = span >> 1;
    se     = ((k_q + RANK_W'(1)) == nsl_q);
    fin    = se && (s_q == (steps_q - STEP_W'(1)));
  end

  always_comb begin
    op = OP_ADD;
    ua = '0;
    ub = '0;
    case (state)
      S_TO: begin
        op = OP_ADD_MOD;
        ua = {1'b0, rank_q};
        ub = stride;
      end
      S_FROM: begin
        op = OP_SUB_MOD;
        ua = {1'b0, rank_q};
        ub = stride;
      end
      S_BACK: begin
        op = OP_ADD_MOD;
        ub = span;
      end
      S_NSL: begin
        ua = cm1_q;
        ub = stride;
      end
      S_EMIT: begin
        op = OP_SUB_MOD;
        ua = {1'b0, tx_q};
        ub = {1'b0, back_q};
      end
      default: op = OP_ADD;
    endcase
  end

  nhrag_modadd u_modadd (
    .op (op),
    .a  (ua),
    .b  (ub),
    .m  (count_q),
    .r  (ur)
  );

  always_comb begin
    preq.clear = accept && !bad;
    preq.valid = (state == S_PRF) || (state == S_PRT);
    preq.rank  = (state == S_PRT) ? to_q : from_q;
  end

  nhrag_peers #(
    .PEER_SLOTS (PEER_SLOTS)
  ) u_peers (
    .clk (clk),
    .rst (rst),
    .req (preq),
    .rsp (prsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            rank_q  <= my_rank;
            count_q <= rank_count;
            cm1_q   <= cm1_in;
            steps_q <= bit_length(cm1_in);
            s_q     <= '0;
            if (bad) begin
              valid        <= 1'b1;
              status       <= 1'b1;
              step_index   <= '0;
              send_rank    <= '0;
              recv_rank    <= '0;
              slice_index  <= '0;
              send_channel <= '0;
              recv_channel <= '0;
              step_end     <= 1'b0;
              last         <= 1'b1;
            end else begin
              state <= S_TO;
            end
          end
        end
        S_TO: begin
          to_q  <= ur[RANK_W-1:0];
          state <= S_FROM;
        end
        S_FROM: begin
          from_q <= ur[RANK_W-1:0];
          state  <= S_BACK;
        end
        S_BACK: begin
          back_q <= ur[RANK_W-1:0];
          state  <= S_NSL;
        end
        S_NSL: begin
          nsl_q <= RANK_W'(ur >> shamt);
          tx_q  <= rank_q;
          k_q   <= '0;
          state <= S_PRF;
        end
        S_PRF: state <= S_PWF;
        S_PWF: begin
          if (prsp.done) begin
            fch_q <= prsp.channel;
            state <= S_PRT;
          end
        end
        S_PRT: state <= S_PWT;
        S_PWT: begin
          if (prsp.done) begin
            tch_q <= prsp.channel;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          valid        <= 1'b1;
          status       <= 1'b0;
          step_index   <= s_q;
          send_rank    <= to_q;
          recv_rank    <= from_q;
          slice_index  <= tx_q;
          send_channel <= tch_q;
          recv_channel <= fch_q;
          step_end     <= se;
          last         <= fin;
          tx_q         <= ur[RANK_W-1:0];
          k_q          <= k_q + RANK_W'(1);
          if (fin) begin
            state <= S_IDLE;
          end else if (se) begin
            s_q   <= s_q + STEP_W'(1);
            state <= S_TO;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- hdl/nhrag_modadd.sv -----
// ----------------------------------------------------------------------------
// NHR all-gather modular adder
// Shared add/subtract unit with one correction step modulo the rank count, or a plain add.
// ----------------------------------------------------------------------------
module nhrag_modadd (
  input  nhrag_pkg::op_t                  op,
  input  logic [nhrag_pkg::CNT_W-1:0]     a,
  input  logic [nhrag_pkg::CNT_W-1:0]     b,
  input  logic [nhrag_pkg::CNT_W-1:0]     m,
  output logic [nhrag_pkg::CNT_W-1:0]     r
);
  import nhrag_pkg::*;

  logic [CNT_W:0] first;
  logic [CNT_W:0] second;
  logic           fix;

  always_comb begin
    if (op == OP_SUB_MOD) begin
      first  = {1'b0, a} - {1'b0, b};
      second = first + {1'b0, m};
    end else begin
      first  = {1'b0, a} + {1'b0, b};
      second = first - {1'b0, m};
    end
    case (op)
      OP_ADD_MOD: fix = (first >= {1'b0, m});
      OP_SUB_MOD: fix = first[CNT_W];
      OP_ADD:     fix = 1'b0;
      default:    fix = 1'b0;
    endcase
    r = fix ? second[CNT_W-1:0] : first[CNT_W-1:0];
  end

endmodule

// ----- hdl/nhrag_peers.sv -----
// ----------------------------------------------------------------------------
// NHR all-gather peer table
// Looks a partner up one entry per cycle and adds a new one in first-seen order while slots remain.
// ----------------------------------------------------------------------------
module nhrag_peers #(
  parameter int PEER_SLOTS = nhrag_pkg::PEER_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nhrag_pkg::peer_req_t req,
  output nhrag_pkg::peer_rsp_t rsp
);
  import nhrag_pkg::*;

  localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

  typedef enum logic [1:0] {
    P_IDLE = 2'b01,
    P_SRCH = 2'b10
  } pstate_t;

  pstate_t           state;
  logic [RANK_W-1:0] peers_mem [PEER_SLOTS];
  logic [CH_W-1:0]   count;
  logic [IW-1:0]     idx;
  logic [RANK_W-1:0] rank_q;
  logic              done;
  logic [CH_W-1:0]   channel;
  logic              hit;
  logic              ins_go;
  logic              full;
  logic [RANK_W-1:0] ins_rank;

  always_comb begin
    hit      = (state == P_SRCH) && (peers_mem[idx] == rank_q);
    ins_go   = ((state == P_IDLE) && req.valid && (count == '0)) ||
               ((state == P_SRCH) && !hit && ((CH_W'(idx) + CH_W'(1)) == count));
    full     = (count == CH_W'(PEER_SLOTS));
    ins_rank = (state == P_IDLE) ? req.rank : rank_q;
  end

  always_ff @(posedge clk) begin
    if (ins_go && !full) begin
      peers_mem[count[IW-1:0]] <= ins_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.clear) begin
        count <= '0;
      end
      if (hit) begin
        done    <= 1'b1;
        channel <= CH_W'(idx);
      end
      if (ins_go) begin
        done <= 1'b1;
        if (full) begin
          channel <= CH_OVF;
        end else begin
          channel <= count;
          count   <= count + CH_W'(1);
        end
      end
      case (state)
        P_IDLE: begin
          if (req.valid) begin
            rank_q <= req.rank;
            idx    <= '0;
            if (count != '0) begin
              state <= P_SRCH;
            end
          end
        end
        P_SRCH: begin
          if (hit || ins_go) begin
            state <= P_IDLE;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  assign rsp.done    = done;
  assign rsp.channel = channel;

endmodule

// ----- hdl/nhrag_chk.sv -----
// ----------------------------------------------------------------------------
// NHR all-gather schedule checker
// Port-level checks on request, busy and result beats of the generator.
// ----------------------------------------------------------------------------
module nhrag_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          valid,
  input logic                          status,
  input logic [nhrag_pkg::STEP_W-1:0]  step_index,
  input logic                          step_end,
  input logic                          last
);

  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    valid && status |-> last && !step_end && (step_index == '0))
    else $error("error beat malformed");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> valid && last)
    else $error("busy dropped without final beat");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || (valid && status && last))
    else $error("accepted request gave neither work nor error beat");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    valid && !status && last |-> step_end)
    else $error("final beat not at end of step");

endmodule

bind nhr_allgather_schedule_gen nhrag_chk u_nhrag_chk (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .valid      (valid),
  .status     (status),
  .step_index (step_index),
  .step_end   (step_end),
  .last       (last)
);

// ----- tb/nhr_allgather_schedule_gen_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NHR all-gather schedule generator testbench
// Sends schedule requests and predicts every beat: step, partners, slice,
// first-seen channels and the step and schedule end flags, or one error beat
// for bad parameters. Beats are checked in order as they appear.
// ----------------------------------------------------------------------------
module nhr_allgather_schedule_gen_test;

  import nhrag_pkg::*;

  localparam int MAX_RANKS   = MAX_RANKS_DEF;
  localparam int PEER_SLOTS  = PEER_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 300;
  localparam int RANDOM_REQS = 340;

  typedef struct packed {
    logic              status;
    logic [STEP_W-1:0] step_index;
    logic [RANK_W-1:0] send_rank;
    logic [RANK_W-1:0] recv_rank;
    logic [RANK_W-1:0] slice_index;
    logic [CH_W-1:0]   send_channel;
    logic [CH_W-1:0]   recv_channel;
    logic              step_end;
    logic              last;
  } sched_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [RANK_W-1:0] my_rank = '0;
  logic [CNT_W-1:0]  rank_count = '0;
  logic              busy;
  logic              valid;
  logic              status;
  logic [STEP_W-1:0] step_index;
  logic [RANK_W-1:0] send_rank;
  logic [RANK_W-1:0] recv_rank;
  logic [RANK_W-1:0] slice_index;
  logic [CH_W-1:0]   send_channel;
  logic [CH_W-1:0]   recv_channel;
  logic              step_end;
  logic              last;

  sched_beat_t       pending_beats[$];
  logic [RANK_W-1:0] peers_known[PEER_SLOTS];
  int                peer_total;
  int                mismatches = 0;
  int                cycle_count = 0;

  nhr_allgather_schedule_gen dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .my_rank      (my_rank),
    .rank_count   (rank_count),
    .valid        (valid),
    .status       (status),
    .step_index   (step_index),
    .send_rank    (send_rank),
    .recv_rank    (recv_rank),
    .slice_index  (slice_index),
    .send_channel (send_channel),
    .recv_channel (recv_channel),
    .step_end     (step_end),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nhr_allgather_schedule_gen_test: done, errors");
      $finish;
    end
  end

  function automatic void queue_beat(input sched_beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic logic [CH_W-1:0] channel_of(input int peer);
    for (int i = 0; i < peer_total && i < PEER_SLOTS; i++) begin
      if (peers_known[i] == peer) return CH_W'(i);
    end
    if (peer_total >= PEER_SLOTS) return CH_OVF;
    peers_known[peer_total] = RANK_W'(peer);
    peer_total++;
    return CH_W'(peer_total - 1);
  endfunction

  function automatic void predict_schedule(input int rank, input int count);
    sched_beat_t beat;
    sched_beat_t held;
    bit          have_held;
    int          steps, stride, to, from, span, nslices, back, tx, n;
    logic [CH_W-1:0] fch, tch;
    peer_total = 0;
    beat = '0;
    if (count < 2 || count > MAX_RANKS || rank >= count) begin
      beat.status = 1'b1;
      beat.last = 1'b1;
      queue_beat(beat);
      return;
    end
    steps = 0;
    for (int v = count - 1; v != 0; v = v >> 1) steps++;
    n = 0;
    have_held = 1'b0;
    held = '0;
    for (int s = 0; s < steps; s++) begin
      stride = 1 << (steps - 1 - s);
      to = (rank + stride) % count;
      from = (rank + count - stride) % count;
      span = 1 << (steps - s);
      nslices = (count - 1 + stride) / span;
      back = span % count;
      fch = channel_of(from);
      tch = channel_of(to);
      tx = rank;
      for (int k = 0; k < nslices && n < 63; k++) begin
        beat = '0;
        beat.step_index = STEP_W'(s);
        beat.send_rank = RANK_W'(to);
        beat.recv_rank = RANK_W'(from);
        beat.slice_index = RANK_W'(tx);
        beat.send_channel = tch;
        beat.recv_channel = fch;
        beat.step_end = (k + 1 == nslices);
        if (have_held) queue_beat(held);
        held = beat;
        have_held = 1'b1;
        n++;
        tx = (tx + count - back) % count;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      queue_beat(held);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_beats
    sched_beat_t want;
    if (!rst && valid) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing outstanding");
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        check_field("status", want.status, status);
        check_field("step_index", want.step_index, step_index);
        check_field("send_rank", want.send_rank, send_rank);
        check_field("recv_rank", want.recv_rank, recv_rank);
        check_field("slice_index", want.slice_index, slice_index);
        check_field("send_channel", want.send_channel, send_channel);
        check_field("recv_channel", want.recv_channel, recv_channel);
        check_field("step_end", want.step_end, step_end);
        check_field("last", want.last, last);
      end
    end
  end

  // hold start and the fields until the generator is no longer busy
  task automatic send_request(input int rank, input int count);
    @(negedge clk);
    start <= 1'b1;
    my_rank <= RANK_W'(rank);
    rank_count <= CNT_W'(count);
    do @(posedge clk); while (busy);
    predict_schedule(rank, count);
  endtask

  task automatic pause(input int cycles);
    repeat (cycles) @(negedge clk) start <= 1'b0;
  endtask

  task automatic test_bad_parameters;
    send_request(0, 0);
    send_request(63, 0);
    send_request(0, 1);
    send_request(1, 1);
    pause(2);
    send_request(0, 65);
    send_request(63, 127);
    send_request(2, 2);
    send_request(63, 63);
    send_request(40, 33);
    pause(3);
  endtask

  task automatic test_directed_schedules;
    send_request(0, 2);
    send_request(1, 2);
    send_request(0, 3);
    pause(1);
    send_request(2, 3);
    send_request(0, 64);
    send_request(63, 64);
    send_request(17, 32);
    pause(5);
    send_request(32, 33);
    send_request(4, 5);
    send_request(0, 17);
    send_request(42, 63);
    send_request(31, 64);
    pause(2);
  endtask

  task automatic test_random_requests;
    int burst_left;
    int rank, count, kind;
    burst_left = 0;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 40));
      end
      burst_left--;
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        count = ($urandom_range(0, 7) == 0) ? MAX_RANKS : $urandom_range(2, MAX_RANKS);
        rank = $urandom_range(0, count - 1);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            count = $urandom_range(0, 1);
            rank = $urandom_range(0, 63);
          end
          1: begin
            count = $urandom_range(MAX_RANKS + 1, 127);
            rank = $urandom_range(0, 63);
          end
          default: begin
            count = $urandom_range(2, 63);
            rank = $urandom_range(count, 63);
          end
        endcase
      end
      send_request(rank, count);
    end
    pause(1);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_bad_parameters();
    test_directed_schedules();
    test_random_requests();
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("nhr_allgather_schedule_gen_test: done, clean");
    end else begin
      $display("nhr_allgather_schedule_gen_test: done, errors");
    end
    $finish;
  end

endmodule
